FILE: rtl/grid_gradient_stencil_defines.svh
// assertion macros for the grid gradient stencil
`ifndef GRID_GRADIENT_STENCIL_DEFINES_SVH
`define GRID_GRADIENT_STENCIL_DEFINES_SVH

// implication on the same edge
`define GGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication on the next edge
`define GGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ggs_pkg.sv
// package with types, register indexes and helpers of the grid gradient stencil
package ggs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCALE,
        ST_SQUARE,
        ST_OUT
    } t_state;

    localparam logic [1:0] REG_GRID_LAST = 2'd0;
    localparam logic [1:0] REG_INV_DX    = 2'd1;
    localparam logic [1:0] REG_INV_DZ    = 2'd2;

    localparam logic [7:0]  GRID_LAST_RST = 8'd64;
    localparam logic [31:0] INV_RST       = 32'd65536;
    localparam logic [7:0]  GRID_LAST_MIN = 8'd3;

    typedef logic signed [35:0] t_acc;

    // row index modulo 3 from its base-4 digits
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s4;
        logic [2:0] s2;
        s4 = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
        s2 = {1'b0, s4[1:0]} + {1'b0, s4[3:2]};
        if (s2 >= 3'd6) begin
            s2 = s2 - 3'd6;
        end else if (s2 >= 3'd3) begin
            s2 = s2 - 3'd3;
        end
        return s2[1:0];
    endfunction

    // rounded product to signed q16.16 with saturation
    function automatic logic signed [31:0] sat_q(input logic [51:0] q, input logic neg);
        logic signed [31:0] res;
        if (neg) begin
            if (q >= 52'h0_0000_8000_0000) begin
                res = 32'sh8000_0000;
            end else begin
                res = -$signed(q[31:0]);
            end
        end else begin
            if (q > 52'h0_0000_7FFF_FFFF) begin
                res = 32'sh7FFF_FFFF;
            end else begin
                res = $signed(q[31:0]);
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/grid_gradient_stencil.sv
// a sample is accepted in idle, then each result passes the read, scale, square and out states in order
// a sample completes k = 0..3 results, k = 0 on rows 0 and 1
// rate is set by the single read port of the three-row line store and one shared multiplier
// a result word is held until taken; no new sample is taken while results are pending
// reset clears the state machine, counters and config registers; the line store is not
// cleared, each frame writes every entry before it is read
module grid_gradient_stencil #(
    parameter int MAX_POINTS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // psi
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [143:0] o_m_tdata,   // row, col, grad_x, grad_z, grad_sq
    output logic         o_m_tlast
);
    import ggs_pkg::*;
`include "grid_gradient_stencil_defines.svh"

    localparam int AW  = $clog2(3 * MAX_POINTS);
    localparam int CAP = (MAX_POINTS - 1 > 255) ? 255 : MAX_POINTS - 1;

    logic [31:0] r_mem [3 * MAX_POINTS];
    logic [31:0] r_rd_data;

    t_state             r_state, n_state;
    logic [2:0]         r_step;
    logic [7:0]         r_grid_last;
    logic [31:0]        r_inv_dx, r_inv_dz;
    logic [7:0]         r_row_cnt, r_col_cnt;
    logic [7:0]         r_pt_row [3];
    logic [7:0]         r_pt_col [3];
    logic [1:0]         r_pt_cnt, r_pt_idx;
    t_acc               r_acc_x, r_acc_z;
    logic [50:0]        r_prod, r_hi;
    logic signed [31:0] r_gx, r_gz;
    logic [63:0]        r_sq, r_sqx, r_sq_sum;

    logic        cfg_wr, s_acc, m_acc, pt_last;
    logic [7:0]  eff_n, cur_r, cur_c, acc_r, acc_c;
    logic [7:0]  rd_pos, rd_row, rd_col, rd_i;
    logic [1:0]  rd_j, wt_j;
    logic        rd_axis, wt_axis;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]  nx_r, nx_c;
    logic [7:0]  bl_row [3];
    logic [7:0]  bl_col [3];
    logic [1:0]  bl_cnt;
    logic signed [3:0] wt;
    t_acc        wsamp;
    logic [34:0] mag_x, mag_z;
    logic [18:0] op_a;
    logic [31:0] op_b;
    logic [51:0] q_sum;

    function automatic logic [AW-1:0] mem_addr(input logic [7:0] row, input logic [7:0] col);
        return AW'(int'(mod3(row)) * MAX_POINTS + int'(col));
    endfunction

    // sample position along an axis for the stencil of index i
    function automatic logic [7:0] samp_pos(input logic [7:0] i, input logic [1:0] j,
                                            input logic [7:0] n);
        logic [7:0] p;
        if (i == 8'd0) begin
            p = {6'd0, j};
        end else if (i >= n) begin
            p = n - {6'd0, j};
        end else begin
            unique case (j)
                2'd0:    p = i + 8'd1;
                2'd1:    p = i - 8'd1;
                default: p = i;
            endcase
        end
        return p;
    endfunction

    function automatic logic signed [3:0] samp_w(input logic [7:0] i, input logic [1:0] j,
                                                input logic [7:0] n);
        logic signed [3:0] w;
        if (i == 8'd0) begin
            unique case (j)
                2'd0:    w = -4'sd3;
                2'd1:    w = 4'sd4;
                default: w = -4'sd1;
            endcase
        end else if (i >= n) begin
            unique case (j)
                2'd0:    w = 4'sd3;
                2'd1:    w = -4'sd4;
                default: w = 4'sd1;
            endcase
        end else begin
            unique case (j)
                2'd0:    w = 4'sd1;
                2'd1:    w = -4'sd1;
                default: w = 4'sd0;
            endcase
        end
        return w;
    endfunction

    function automatic t_acc apply_w(input logic [31:0] d, input logic signed [3:0] w);
        t_acc s;
        t_acc v;
        s = t_acc'($signed(d));
        unique case (w)
            4'sd1:   v = s;
            -4'sd1:  v = -s;
            4'sd3:   v = s + (s <<< 1);
            -4'sd3:  v = -(s + (s <<< 1));
            4'sd4:   v = s <<< 2;
            -4'sd4:  v = -(s <<< 2);
            default: v = '0;
        endcase
        return v;
    endfunction

    assign eff_n = (r_grid_last < GRID_LAST_MIN) ? GRID_LAST_MIN :
                   (32'(r_grid_last) > 32'(CAP)) ? 8'(CAP) : r_grid_last;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_GRID_LAST: prdata = {24'd0, r_grid_last};
            REG_INV_DX:    prdata = r_inv_dx;
            REG_INV_DZ:    prdata = r_inv_dz;
            default:       prdata = '0;
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == ST_OUT);
    assign m_acc      = o_m_tvalid && i_m_tready;
    assign pt_last    = (r_pt_idx == r_pt_cnt - 2'd1);

    assign cur_r = r_pt_row[r_pt_idx];
    assign cur_c = r_pt_col[r_pt_idx];
    assign o_m_tdata = {r_sq_sum, r_gz, r_gx, cur_c, cur_r};
    assign o_m_tlast = pt_last;

    // sample position of the accepted word and the points it completes
    always_comb begin
        acc_r = r_row_cnt;
        acc_c = r_col_cnt;
        if (acc_r > eff_n || acc_c > eff_n) begin
            acc_r = '0;
            acc_c = '0;
        end
        wr_addr = mem_addr(acc_r, acc_c);
        bl_cnt = '0;
        bl_row[0] = '0; bl_row[1] = '0; bl_row[2] = '0;
        bl_col[0] = '0; bl_col[1] = '0; bl_col[2] = '0;
        if (acc_r >= 8'd2) begin
            if (acc_r == 8'd2) begin
                bl_row[bl_cnt] = 8'd0;
                bl_col[bl_cnt] = acc_c;
                bl_cnt = bl_cnt + 2'd1;
            end
            bl_row[bl_cnt] = acc_r - 8'd1;
            bl_col[bl_cnt] = acc_c;
            bl_cnt = bl_cnt + 2'd1;
            if (acc_r == eff_n) begin
                if (acc_c == 8'd2) begin
                    bl_row[bl_cnt] = eff_n;
                    bl_col[bl_cnt] = 8'd0;
                    bl_cnt = bl_cnt + 2'd1;
                    bl_row[bl_cnt] = eff_n;
                    bl_col[bl_cnt] = 8'd1;
                    bl_cnt = bl_cnt + 2'd1;
                end else if (acc_c > 8'd2) begin
                    bl_row[bl_cnt] = eff_n;
                    bl_col[bl_cnt] = acc_c - 8'd1;
                    bl_cnt = bl_cnt + 2'd1;
                end
                if (acc_c == eff_n) begin
                    bl_row[bl_cnt] = eff_n;
                    bl_col[bl_cnt] = eff_n;
                    bl_cnt = bl_cnt + 2'd1;
                end
            end
        end
        nx_r = acc_r;
        nx_c = acc_c + 8'd1;
        if (acc_c >= eff_n) begin
            nx_c = '0;
            nx_r = (acc_r >= eff_n) ? 8'd0 : acc_r + 8'd1;
        end
    end

    // stencil reads: samples 0..2 along x, 3..5 along z
    always_comb begin
        rd_axis = (r_step >= 3'd3);
        rd_j    = rd_axis ? 2'(r_step - 3'd3) : r_step[1:0];
        rd_i    = rd_axis ? cur_c : cur_r;
        rd_pos  = samp_pos(rd_i, rd_j, eff_n);
        rd_row  = rd_axis ? cur_r : rd_pos;
        rd_col  = rd_axis ? rd_pos : cur_c;
        rd_addr = mem_addr(rd_row, rd_col);
        wt_axis = (r_step >= 3'd4);
        wt_j    = wt_axis ? 2'(r_step - 3'd4) : 2'(r_step - 3'd1);
        wt      = samp_w(wt_axis ? cur_c : cur_r, wt_j, eff_n);
        wsamp   = apply_w(r_rd_data, wt);
    end

    // operands of the shared multiplier
    always_comb begin
        mag_x = 35'(r_acc_x[35] ? -r_acc_x : r_acc_x);
        mag_z = 35'(r_acc_z[35] ? -r_acc_z : r_acc_z);
        unique case (r_step)
            3'd0:    begin op_a = mag_x[34:16];          op_b = r_inv_dx; end
            3'd1:    begin op_a = {3'd0, mag_x[15:0]};   op_b = r_inv_dx; end
            3'd2:    begin op_a = mag_z[34:16];          op_b = r_inv_dz; end
            3'd3:    begin op_a = {3'd0, mag_z[15:0]};   op_b = r_inv_dz; end
            default: begin op_a = '0;                    op_b = '0;       end
        endcase
        q_sum = {1'b0, r_hi} + 52'((r_prod + 51'h8000) >> 16);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (s_acc && bl_cnt != 2'd0) n_state = ST_READ;
            ST_READ:   if (r_step == 3'd6) n_state = ST_SCALE;
            ST_SCALE:  if (r_step == 3'd4) n_state = ST_SQUARE;
            ST_SQUARE: if (r_step == 3'd2) n_state = ST_OUT;
            ST_OUT:    if (m_acc) n_state = pt_last ? ST_IDLE : ST_READ;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (s_acc) begin
            r_mem[wr_addr] <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_grid_last <= GRID_LAST_RST;
            r_inv_dx    <= INV_RST;
            r_inv_dz    <= INV_RST;
            r_row_cnt   <= '0;
            r_col_cnt   <= '0;
            r_pt_cnt    <= '0;
            r_pt_idx    <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state != r_state) ? 3'd0 : r_step + 3'd1;
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_GRID_LAST: begin
                        r_grid_last <= pwdata[7:0];
                        r_row_cnt   <= '0;
                        r_col_cnt   <= '0;
                    end
                    REG_INV_DX: r_inv_dx <= pwdata;
                    REG_INV_DZ: r_inv_dz <= pwdata;
                    default: ;
                endcase
            end
            if (s_acc) begin
                r_row_cnt <= nx_r;
                r_col_cnt <= nx_c;
                r_pt_cnt  <= bl_cnt;
                r_pt_idx  <= '0;
            end
            if (m_acc && !pt_last) begin
                r_pt_idx <= r_pt_idx + 2'd1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_pt_row <= bl_row;
            r_pt_col <= bl_col;
        end
        unique case (r_state)
            ST_IDLE, ST_OUT: begin
                r_acc_x <= '0;
                r_acc_z <= '0;
            end
            ST_READ: begin
                if (r_step != 3'd0) begin
                    if (wt_axis) r_acc_z <= r_acc_z + wsamp;
                    else         r_acc_x <= r_acc_x + wsamp;
                end
            end
            ST_SCALE: begin
                r_prod <= 51'(op_a) * 51'(op_b);
                if (r_step == 3'd1 || r_step == 3'd3) r_hi <= r_prod;
                if (r_step == 3'd2) r_gx <= sat_q(q_sum, r_acc_x[35]);
                if (r_step == 3'd4) r_gz <= sat_q(q_sum, r_acc_z[35]);
            end
            ST_SQUARE: begin
                if (r_step == 3'd0) r_sq <= 64'(r_gx) * 64'(r_gx);
                if (r_step == 3'd1) begin
                    r_sqx <= r_sq;
                    r_sq  <= 64'(r_gz) * 64'(r_gz);
                end
                if (r_step == 3'd2) r_sq_sum <= r_sqx + r_sq;
            end
            default: ;
        endcase
    end

    `GGS_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, m_acc && pt_last, r_state == ST_IDLE, "last word did not return to idle")
    `GGS_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_state != ST_IDLE, r_pt_idx < r_pt_cnt && r_pt_cnt <= 2'd3, "point index out of range")
    `GGS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_row_cnt <= eff_n && r_col_cnt <= eff_n, "counters beyond grid")

endmodule
